// ----- sv/rrvi_pkg.sv -----
package rrvi_pkg;

    localparam int WINDOW_MAX = 64;

    localparam int SAMPLE_W = 32;
    localparam int N_W      = 7;
    localparam int P_W      = 11;
    localparam int PSUM_W   = 40;
    localparam int WSUM_W   = 48;
    localparam int EMA_W    = 48;
    localparam int D_W      = 14;
    localparam int R_W      = 36;
    localparam int CHUNK_W  = 14;
    localparam int MA_W     = 48;
    localparam int PROD_W   = MA_W + CHUNK_W + 1;
    localparam int ACC_W    = 74;
    localparam int DIV_W    = 72;
    localparam int DVS_W    = 49;
    localparam int IDX_W    = 23;
    localparam int ADDR_W   = 3;
    localparam int K_W      = 2;

    localparam int R_CHUNKS = (R_W + CHUNK_W - 1) / CHUNK_W;
    localparam int G_CHUNKS = (EMA_W + CHUNK_W - 1) / CHUNK_W;

    localparam logic [N_W-1:0]    WINDOW_RESET = 7'd14;
    localparam logic [P_W-1:0]    PERIOD_RESET = 11'd10;
    localparam logic [P_W-1:0]    PERIOD_MAX   = 11'd1024;
    localparam logic [IDX_W-1:0]  FIFTY_Q16    = 23'd3276800;
    localparam logic [IDX_W-1:0]  HUNDRED_Q16  = 23'd6553600;
    localparam logic [EMA_W-1:0]  TERM_MAX     = {EMA_W{1'b1}};

    localparam logic [ADDR_W-1:0] ADDR_WINDOW  = 3'd0;
    localparam logic [ADDR_W-1:0] ADDR_PERIOD  = 3'd4;

endpackage

// ----- sv/rrvi_divider.sv -----
module rrvi_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rrvi_pkg::DIV_W-1:0]  dividend,
    input  logic [rrvi_pkg::DVS_W-1:0]  divisor,
    output logic                        done,
    output logic [rrvi_pkg::DIV_W-1:0]  quotient
);
    import rrvi_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] quo_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   shifted;
    logic             fits;

    // restoring division, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_W'(DIV_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? DVS_W'(shifted - {1'b0, dvs_reg}) : shifted[DVS_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- sv/regression_residual_volatility_index.sv -----
// Regression residual volatility index. Each accepted sample (signed Q16.16)
// joins a window of N = window_length samples; the newest sample's residual
// from the least-squares line over the window feeds a gain or loss EMA with
// factor 2/(P+1), P = smoothing_period, and the result is
// 100*gain/(gain+loss) in unsigned Q7.16, or 50.0 while the gain is zero.
// The first N-1 samples of a series give no result. series_start, and any
// register write, begin a new series. The bit-serial divider runs a 72-step
// division for the residual, the squared term and the EMA step of each
// sample that gives a result, and one for the index unless the gain is zero.
// A shared 48-by-14-bit multiplier does the products.
// Results wait in an output register, and the next sample may be taken
// while one waits.
module regression_residual_volatility_index (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rrvi_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic signed [rrvi_pkg::SAMPLE_W-1:0] sample,
    input  logic                           series_start,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [rrvi_pkg::IDX_W-1:0]     index_value
);
    import rrvi_pkg::*;

    localparam int PTR_W = $clog2(WINDOW_MAX);

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_WSUM, ST_DPROD, ST_NUM1, ST_NUM2, ST_NUM3,
        ST_RLAUNCH, ST_RWAIT, ST_SQ, ST_TLAUNCH, ST_TWAIT, ST_ELAUNCH,
        ST_EWAIT, ST_IDX, ST_IMUL, ST_ILAUNCH, ST_IWAIT, ST_DONE
    } state_t;

    state_t                    state_reg;
    logic [N_W-1:0]            window_length_reg;
    logic [P_W-1:0]            smoothing_period_reg;
    logic [N_W-1:0]            n_reg;
    logic [P_W-1:0]            p_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic                      start_reg;
    logic [PTR_W-1:0]          ptr_reg;
    logic [N_W-1:0]            warmup_reg;
    logic signed [PSUM_W-1:0]  plain_reg;
    logic signed [WSUM_W-1:0]  weighted_reg;
    logic [EMA_W-1:0]          gain_reg;
    logic [EMA_W-1:0]          loss_reg;
    logic [D_W-1:0]            d_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [R_W-1:0]            r_reg;
    logic [EMA_W-1:0]          term_reg;
    logic                      num_pos_reg;
    logic                      ema_neg_reg;
    logic [K_W-1:0]            k_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic                      result_valid_reg;
    logic [IDX_W-1:0]          result_reg;
    logic [SAMPLE_W-1:0]       old_reg;

    logic [SAMPLE_W-1:0]       window_mem [WINDOW_MAX];

    logic                      cfg_write;
    logic [N_W-1:0]            n_clamped;
    logic [P_W-1:0]            p_clamped;
    logic                      warm;
    logic [PTR_W-1:0]          ptr_inc;
    logic [PTR_W:0]            old_sum;
    logic [PTR_W-1:0]          old_addr;
    logic [PTR_W-1:0]          wr_addr;

    logic signed [MA_W-1:0]    mul_a;
    logic [CHUNK_W-1:0]        mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [ACC_W-1:0]   prod_sh;
    logic [R_CHUNKS*CHUNK_W-1:0] r_ext;
    logic [G_CHUNKS*CHUNK_W-1:0] g_ext;

    logic [ACC_W-1:0]          num_mag;
    logic [ACC_W-1:0]          sq_round;
    logic [P_W-1:0]            p_plus;
    logic [EMA_W-1:0]          ema_cur;
    logic signed [EMA_W:0]     ema_diff;
    logic [EMA_W:0]            ema_mag;
    logic [EMA_W:0]            ema_sum;
    logic [EMA_W:0]            step;
    logic [EMA_W+1:0]          ema_up;
    logic [EMA_W-1:0]          ema_new;

    logic                      div_start;
    logic [DIV_W-1:0]          div_dividend;
    logic [DVS_W-1:0]          div_divisor;
    logic                      div_done;
    logic [DIV_W-1:0]          div_q;
    logic                      out_free;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr)
            ADDR_WINDOW: prdata = 32'(window_length_reg);
            ADDR_PERIOD: prdata = 32'(smoothing_period_reg);
            default:     prdata = '0;
        endcase
    end

    always_comb
    begin
        priority if (window_length_reg == '0)
            n_clamped = N_W'(1);
        else if (32'(window_length_reg) > WINDOW_MAX)
            n_clamped = N_W'(WINDOW_MAX);
        else
            n_clamped = window_length_reg;
        priority if (smoothing_period_reg == '0)
            p_clamped = P_W'(1);
        else if (smoothing_period_reg > PERIOD_MAX)
            p_clamped = PERIOD_MAX;
        else
            p_clamped = smoothing_period_reg;
    end

    assign warm     = ({1'b0, warmup_reg} + 1'b1) < {1'b0, n_reg};
    assign ptr_inc  = (32'(ptr_reg) == WINDOW_MAX - 1) ? '0 : ptr_reg + 1'b1;
    assign old_sum  = {1'b0, ptr_reg} + (PTR_W+1)'(WINDOW_MAX)
                    - (PTR_W+1)'(n_reg - 1'b1);
    assign old_addr = (32'(old_sum) >= WINDOW_MAX)
                    ? PTR_W'(old_sum - (PTR_W+1)'(WINDOW_MAX)) : old_sum[PTR_W-1:0];
    assign wr_addr  = start_reg ? '0 : ptr_reg;

    // shared multiplier operand select
    assign r_ext = (R_CHUNKS*CHUNK_W)'(r_reg);
    assign g_ext = (G_CHUNKS*CHUNK_W)'(gain_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_WSUM:
            begin
                mul_a = MA_W'(y_reg);
                mul_b = warm ? CHUNK_W'(warmup_reg + 1'b1) : CHUNK_W'(n_reg);
            end
            ST_DPROD:
            begin
                mul_a = MA_W'({1'b0, n_reg});
                mul_b = CHUNK_W'({1'b0, n_reg} + 1'b1);
            end
            ST_NUM1:
            begin
                mul_a = MA_W'(y_reg);
                mul_b = d_reg;
            end
            ST_NUM2:
            begin
                mul_a = MA_W'(plain_reg);
                mul_b = CHUNK_W'({({1'b0, n_reg} + 1'b1), 1'b0});
            end
            ST_NUM3:
            begin
                mul_a = weighted_reg;
                mul_b = CHUNK_W'(6);
            end
            ST_SQ:
            begin
                mul_a = MA_W'({1'b0, r_reg});
                mul_b = r_ext[k_reg*CHUNK_W +: CHUNK_W];
            end
            ST_IMUL:
            begin
                mul_a = MA_W'({1'b0, HUNDRED_Q16});
                mul_b = g_ext[k_reg*CHUNK_W +: CHUNK_W];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod     = mul_a * $signed({1'b0, mul_b});
    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    assign prod_sh  = prod_ext << (k_reg * CHUNK_W);

    // divider operand select
    assign num_mag  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign sq_round = ACC_W'(acc_reg) + ACC_W'({n_reg, 15'd0});
    assign p_plus   = p_reg + 1'b1;
    assign ema_cur  = num_pos_reg ? gain_reg : loss_reg;
    assign ema_diff = $signed({1'b0, term_reg}) - $signed({1'b0, ema_cur});
    assign ema_mag  = ema_diff[EMA_W] ? (EMA_W+1)'(-ema_diff) : (EMA_W+1)'(ema_diff);
    assign ema_sum  = {1'b0, gain_reg} + {1'b0, loss_reg};

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (state_reg)
            ST_RLAUNCH:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(num_mag) + DIV_W'(d_reg[D_W-1:1]);
                div_divisor  = DVS_W'(d_reg);
            end
            ST_TLAUNCH:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(sq_round >> 16);
                div_divisor  = DVS_W'(n_reg);
            end
            ST_ELAUNCH:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({ema_mag, 1'b0}) + DIV_W'(p_plus[P_W-1:1]);
                div_divisor  = DVS_W'(p_plus);
            end
            ST_ILAUNCH:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'(acc_reg) + DIV_W'(ema_sum >> 1);
                div_divisor  = ema_sum;
            end
            default:
            begin
                div_start    = 1'b0;
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    rrvi_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign step    = div_q[EMA_W:0];
    assign ema_up  = {1'b0, ema_cur} + {1'b0, step};
    always_comb
    begin
        if (ema_neg_reg)
            ema_new = (step > {1'b0, ema_cur}) ? '0 : EMA_W'({1'b0, ema_cur} - step);
        else
            ema_new = (ema_up > (EMA_W+2)'(TERM_MAX)) ? TERM_MAX : ema_up[EMA_W-1:0];
    end

    assign out_free = !result_valid_reg || result_ready;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
            window_mem[wr_addr] <= y_reg;
        if (state_reg == ST_DPROD)
            old_reg <= window_mem[old_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= ST_IDLE;
            window_length_reg    <= WINDOW_RESET;
            smoothing_period_reg <= PERIOD_RESET;
            n_reg                <= '0;
            p_reg                <= '0;
            y_reg                <= '0;
            start_reg            <= 1'b0;
            ptr_reg              <= '0;
            warmup_reg           <= '0;
            plain_reg            <= '0;
            weighted_reg         <= '0;
            gain_reg             <= '0;
            loss_reg             <= '0;
            d_reg                <= '0;
            acc_reg              <= '0;
            r_reg                <= '0;
            term_reg             <= '0;
            num_pos_reg          <= 1'b0;
            ema_neg_reg          <= 1'b0;
            k_reg                <= '0;
            idx_reg              <= '0;
            result_valid_reg     <= 1'b0;
            result_reg           <= '0;
        end
        else
        begin
            if (result_valid_reg && result_ready && state_reg != ST_DONE)
                result_valid_reg <= 1'b0;

            if (cfg_write && (paddr == ADDR_WINDOW || paddr == ADDR_PERIOD))
            begin
                if (paddr == ADDR_WINDOW)
                    window_length_reg <= pwdata[N_W-1:0];
                else
                    smoothing_period_reg <= pwdata[P_W-1:0];
                ptr_reg      <= '0;
                warmup_reg   <= '0;
                plain_reg    <= '0;
                weighted_reg <= '0;
                gain_reg     <= '0;
                loss_reg     <= '0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        y_reg     <= sample;
                        start_reg <= series_start;
                        n_reg     <= n_clamped;
                        p_reg     <= p_clamped;
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    if (start_reg)
                    begin
                        ptr_reg      <= '0;
                        warmup_reg   <= '0;
                        plain_reg    <= '0;
                        weighted_reg <= '0;
                        gain_reg     <= '0;
                        loss_reg     <= '0;
                    end
                    state_reg <= ST_WSUM;
                end
                ST_WSUM:
                begin
                    weighted_reg <= weighted_reg + WSUM_W'(prod);
                    plain_reg    <= plain_reg + PSUM_W'(y_reg);
                    if (warm)
                    begin
                        warmup_reg <= warmup_reg + 1'b1;
                        ptr_reg    <= ptr_inc;
                        state_reg  <= ST_IDLE;
                    end
                    else
                        state_reg <= ST_DPROD;
                end
                ST_DPROD:
                begin
                    d_reg     <= prod[D_W-1:0];
                    state_reg <= ST_NUM1;
                end
                ST_NUM1:
                begin
                    acc_reg   <= prod_ext;
                    state_reg <= ST_NUM2;
                end
                ST_NUM2:
                begin
                    acc_reg   <= acc_reg + prod_ext;
                    state_reg <= ST_NUM3;
                end
                ST_NUM3:
                begin
                    acc_reg   <= acc_reg - prod_ext;
                    state_reg <= ST_RLAUNCH;
                end
                ST_RLAUNCH:
                begin
                    // zero residual counts as a loss
                    num_pos_reg <= !acc_reg[ACC_W-1] && (acc_reg != '0);
                    state_reg   <= ST_RWAIT;
                end
                ST_RWAIT:
                begin
                    if (div_done)
                    begin
                        r_reg     <= div_q[R_W-1:0];
                        acc_reg   <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    acc_reg <= acc_reg + prod_sh;
                    k_reg   <= k_reg + 1'b1;
                    if (k_reg == K_W'(R_CHUNKS - 1))
                        state_reg <= ST_TLAUNCH;
                end
                ST_TLAUNCH:
                begin
                    state_reg <= ST_TWAIT;
                end
                ST_TWAIT:
                begin
                    if (div_done)
                    begin
                        term_reg  <= (|div_q[DIV_W-1:EMA_W]) ? TERM_MAX : div_q[EMA_W-1:0];
                        state_reg <= ST_ELAUNCH;
                    end
                end
                ST_ELAUNCH:
                begin
                    ema_neg_reg <= ema_diff[EMA_W];
                    state_reg   <= ST_EWAIT;
                end
                ST_EWAIT:
                begin
                    if (div_done)
                    begin
                        if (num_pos_reg)
                            gain_reg <= ema_new;
                        else
                            loss_reg <= ema_new;
                        state_reg <= ST_IDX;
                    end
                end
                ST_IDX:
                begin
                    acc_reg <= '0;
                    k_reg   <= '0;
                    if (gain_reg == '0)
                    begin
                        idx_reg   <= FIFTY_Q16;
                        state_reg <= ST_DONE;
                    end
                    else
                        state_reg <= ST_IMUL;
                end
                ST_IMUL:
                begin
                    acc_reg <= acc_reg + prod_sh;
                    k_reg   <= k_reg + 1'b1;
                    if (k_reg == K_W'(G_CHUNKS - 1))
                        state_reg <= ST_ILAUNCH;
                end
                ST_ILAUNCH:
                begin
                    state_reg <= ST_IWAIT;
                end
                ST_IWAIT:
                begin
                    if (div_done)
                    begin
                        idx_reg   <= div_q[IDX_W-1:0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    // hold until the output register is free, then slide the window
                    if (out_free)
                    begin
                        weighted_reg     <= weighted_reg - WSUM_W'(plain_reg);
                        plain_reg        <= plain_reg - PSUM_W'($signed(old_reg));
                        ptr_reg          <= ptr_inc;
                        result_reg       <= idx_reg;
                        result_valid_reg <= 1'b1;
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign index_value  = result_reg;

endmodule
